@@ sv/pcmi_pkg.sv @@
// Shared types, constants and hash helper for the PCM16 stream inspector.
package pcmi_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int SUM_BITS       = 40;
    localparam int SEEN_BITS      = 24;
    localparam int TDATA_BITS     = 136;
    localparam int TUSER_BITS     = 2;

    localparam logic [31:0]        FNV_BASIS  = 32'h811C_9DC5;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic                  sample_valid;
        logic [7:0]            duty_value;
        logic [31:0]           running_hash;
        logic signed [15:0]    min_sample;
        logic signed [15:0]    max_sample;
        logic [SUM_BITS-1:0]   abs_sum;
        logic [SEEN_BITS-1:0]  samples_seen;
        logic                  length_error;
    } result_t;

    // multiply by the FNV prime 16777619 = 2^24 + 403, 403 = 256+128+16+2+1
    function automatic logic [31:0] fnv_mul(input logic [31:0] h);
        fnv_mul = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

@@ sv/pcmi_core.sv @@
// Inspector state registers and the per-byte update logic.
module pcmi_core #(
    parameter int COUNT_BITS = pcmi_pkg::COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  pcmi_pkg::in_item_t item,
    output pcmi_pkg::result_t  res
);
    import pcmi_pkg::*;

    logic [31:0]           hash_reg, hash_next;
    logic [7:0]            hold_reg, hold_next;
    logic                  odd_reg, odd_next;
    logic signed [15:0]    min_reg, min_next;
    logic signed [15:0]    max_reg, max_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // state as seen by this byte, after an optional start clear
    logic [31:0]           base_hash;
    logic [7:0]            base_hold;
    logic                  base_odd;
    logic signed [15:0]    base_min;
    logic signed [15:0]    base_max;
    logic [SUM_BITS-1:0]   base_sum;
    logic [COUNT_BITS-1:0] base_count;

    logic [15:0]           raw;
    logic signed [15:0]    smp;
    logic [16:0]           mag;
    logic [SUM_BITS:0]     sum_wide;
    logic [31:0]           count_ext;

    always_comb begin
        base_hash  = item.start_req ? FNV_BASIS  : hash_reg;
        base_hold  = item.start_req ? 8'd0       : hold_reg;
        base_odd   = item.start_req ? 1'b0       : odd_reg;
        base_min   = item.start_req ? SAMPLE_MAX : min_reg;
        base_max   = item.start_req ? SAMPLE_MIN : max_reg;
        base_sum   = item.start_req ? '0         : sum_reg;
        base_count = item.start_req ? '0         : count_reg;

        hash_next = fnv_mul(base_hash ^ {24'd0, item.data_byte});

        raw      = {item.data_byte, base_hold};
        smp      = signed'(raw);
        // |s| of a negative sample is 65536 - raw, which gives 32768 for -32768
        mag      = raw[15] ? 17'(17'h1_0000 - {1'b0, raw}) : {1'b0, raw};
        sum_wide = {1'b0, base_sum} + (SUM_BITS+1)'(mag);

        hold_next  = base_hold;
        odd_next   = base_odd;
        min_next   = base_min;
        max_next   = base_max;
        sum_next   = base_sum;
        count_next = base_count;

        res.sample_valid = 1'b0;
        res.duty_value   = 8'd0;

        if (!base_odd) begin
            hold_next = item.data_byte;
            odd_next  = 1'b1;
        end else begin
            odd_next = 1'b0;
            if (smp < base_min) begin
                min_next = smp;
            end
            if (smp > base_max) begin
                max_next = smp;
            end
            sum_next = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
            if (base_count != {COUNT_BITS{1'b1}}) begin
                count_next = base_count + 1'b1;
            end
            res.sample_valid = 1'b1;
            res.duty_value   = {~raw[15], raw[14:8]};
        end

        count_ext = 32'(count_next);

        res.running_hash = hash_next;
        res.min_sample   = min_next;
        res.max_sample   = max_next;
        res.abs_sum      = sum_next;
        res.samples_seen = count_ext[SEEN_BITS-1:0];
        res.length_error = item.last & odd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= FNV_BASIS;
            hold_reg  <= 8'd0;
            odd_reg   <= 1'b0;
            min_reg   <= SAMPLE_MAX;
            max_reg   <= SAMPLE_MIN;
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (advance) begin
            hash_reg  <= hash_next;
            hold_reg  <= hold_next;
            odd_reg   <= odd_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    // with no samples counted, the statistics must still hold their cleared values
    a_empty_stats: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> (min_reg == SAMPLE_MAX && max_reg == SAMPLE_MIN && sum_reg == '0))
        else $error("statistics not cleared while count is zero");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> min_reg <= max_reg)
        else $error("min above max after a sample");

    a_count_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.sample_valid |=> count_reg != '0 && !odd_reg)
        else $error("completed sample not counted");
`endif

endmodule

@@ sv/pcmi_out_buf.sv @@
// Two-entry output buffer: registered result word plus a skid entry.
module pcmi_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcmi_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pcmi_pkg::result_t out_data
);
    import pcmi_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !main_valid_reg) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_reg <= in_data;
        end
    end

endmodule

@@ sv/pcm16_stream_inspector.sv @@
// Top level of the PCM16 stream inspector: input register, update core, output buffer.
//
//  channel | dir | tdata                         | tuser                       | tlast
//  s_      | in  | [7:0] data_byte               | start_req                   | last
//  m_      | out | duty, hash, min, max, sum, n  | [0] sample_valid, [1] lerr  | -
//
// One byte per cycle while m_ is not stalled; each word passes the input and main registers.
// The hash, min/max, sum and count registers in the core update once for each byte advanced.
// Reset clears the state to the FNV basis and empty statistics; start_req does so per word.
// A stall on m_ fills the skid entry first; s_tready drops only when both stages are held.
module pcm16_stream_inspector #(
    parameter int COUNT_BITS = pcmi_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] data_byte
    input  logic                              s_tuser,  // start_req
    input  logic                              s_tlast,  // last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] duty_value, [39:8] running_hash, [55:40] min_sample, [71:56] max_sample,
    // [111:72] abs_sum, [135:112] samples_seen
    output logic [pcmi_pkg::TDATA_BITS-1:0]   m_tdata,
    output logic [pcmi_pkg::TUSER_BITS-1:0]   m_tuser   // [0] sample_valid, [1] length_error
);
    import pcmi_pkg::*;

    logic     in_valid_reg;
    in_item_t in_reg;
    logic     buf_ready;
    logic     advance;
    result_t  core_res;
    result_t  out_res;

    assign advance  = in_valid_reg && buf_ready;
    assign s_tready = !in_valid_reg || buf_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.data_byte <= s_tdata;
            in_reg.start_req <= s_tuser;
            in_reg.last      <= s_tlast;
        end
    end

    pcmi_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(advance),
        .item   (in_reg),
        .res    (core_res)
    );

    pcmi_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_ready (buf_ready),
        .in_data  (core_res),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_res)
    );

    assign m_tdata = {out_res.samples_seen, out_res.abs_sum, out_res.max_sample,
                      out_res.min_sample, out_res.running_hash, out_res.duty_value};
    assign m_tuser = {out_res.length_error, out_res.sample_valid};

endmodule
